// ===== rtl/tvbe_pkg.sv =====
// Shared constants, codes and types for the vector byte encoder.
package tvbe_pkg;

  localparam int RAW_W = 16;
  localparam int RAW_UNITS_PER_INCH = 600;
  localparam int DEVICE_UNITS_PER_INCH = 100;
  localparam int MAX_X = 1000;
  localparam int MAX_Y = 750;

  // Scaled coordinate: MAX_X and MAX_Y stay below 1024.
  localparam int COORD_W = 10;
  // raw * DEVICE_UNITS_PER_INCH fits here.
  localparam int PROD_W = RAW_W + $clog2(DEVICE_UNITS_PER_INCH + 1);
  // Reciprocal of RAW_UNITS_PER_INCH, scaled by 2^PROD_W.
  localparam int RECIP_SHIFT = PROD_W;
  localparam int RECIP_W = PROD_W + 1;
  localparam longint unsigned RECIP_VAL =
      (64'd1 << RECIP_SHIFT) / RAW_UNITS_PER_INCH;

  localparam int MAX_BYTES = 7;
  localparam int CNT_W = 3;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_ERASE = 3'd1;
  localparam logic [2:0] OP_MOVE  = 3'd2;
  localparam logic [2:0] OP_DRAW  = 3'd3;
  localparam logic [2:0] OP_DONE  = 3'd4;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_GS  = 8'h1D;
  localparam logic [7:0] CH_US  = 8'h1F;

  localparam logic [2:0] TAG_HI   = 3'b001;
  localparam logic [1:0] TAG_LO_Y = 2'b11;
  localparam logic [1:0] TAG_LO_X = 2'b10;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_ALPHA   = 2'd1,
    MODE_VECTOR  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       lost;
    logic [7:0] hi_y;
    logic [7:0] lo_y;
    logic [7:0] hi_x;
    logic [7:0] lo_x;
  } term_state_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// ===== rtl/tvbe_scale.sv =====
// Three-stage scaler: raw * device units / raw units, truncated, then clamped.
module tvbe_scale (
  input  logic                        clk,
  input  tvbe_pkg::stage_en_t         en,
  input  logic [tvbe_pkg::RAW_W-1:0]   raw,
  input  logic [tvbe_pkg::COORD_W-1:0] limit,
  output logic [tvbe_pkg::COORD_W-1:0] scaled
);

  localparam int PW = tvbe_pkg::PROD_W;
  localparam int RW = tvbe_pkg::RECIP_W;
  localparam int SH = tvbe_pkg::RECIP_SHIFT;

  logic [PW-1:0]    prod2;
  logic [PW-1:0]    prod3;
  logic [PW-1:0]    quot3;
  logic [PW-1:0]    prod4;
  logic [PW-1:0]    quot4;
  logic [PW-1:0]    back4;
  logic [PW+RW-1:0] recip_prod;
  logic [PW-1:0]    rem4;
  logic [PW-1:0]    quot;

  assign recip_prod = (PW+RW)'(prod2) * (PW+RW)'(tvbe_pkg::RECIP_VAL[RW-1:0]);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod2 <= PW'(raw) * PW'(tvbe_pkg::DEVICE_UNITS_PER_INCH);
    end
    if (en.s3) begin
      prod3 <= prod2;
      quot3 <= recip_prod[SH+PW-1:SH];
    end
    if (en.s4) begin
      prod4 <= prod3;
      quot4 <= quot3;
      back4 <= PW'(quot3 * PW'(tvbe_pkg::RAW_UNITS_PER_INCH));
    end
  end

  // The estimate is low by at most one: fix it with the remainder.
  always_comb begin
    rem4 = prod4 - back4;
    quot = (rem4 >= PW'(tvbe_pkg::RAW_UNITS_PER_INCH)) ? quot4 + PW'(1) : quot4;
    scaled = (quot > PW'(limit)) ? limit : quot[tvbe_pkg::COORD_W-1:0];
  end

endmodule

// ===== rtl/tvbe_encode.sv =====
// Byte list and next terminal state for one command.
module tvbe_encode (
  input  logic [2:0]                    operation,
  input  logic [tvbe_pkg::COORD_W-1:0]  x,
  input  logic [tvbe_pkg::COORD_W-1:0]  y,
  input  tvbe_pkg::term_state_t         cur,
  output logic [7:0]                    bytes [tvbe_pkg::MAX_BYTES],
  output logic [tvbe_pkg::CNT_W-1:0]    count,
  output tvbe_pkg::term_state_t         nxt
);

  logic [tvbe_pkg::COORD_W-1:0] px;
  logic [tvbe_pkg::COORD_W-1:0] py;
  logic [7:0] hy;
  logic [7:0] ly;
  logic [7:0] hx;
  logic [7:0] lx;
  logic chy;
  logic cly;
  logic chx;
  logic clx;
  logic is_point;
  logic [tvbe_pkg::CNT_W-1:0] idx;

  always_comb begin
    is_point = (operation == tvbe_pkg::OP_MOVE) || (operation == tvbe_pkg::OP_DRAW) ||
               (operation == tvbe_pkg::OP_DONE);
    // done parks the beam at the origin
    px = (operation == tvbe_pkg::OP_DONE) ? '0 : x;
    py = (operation == tvbe_pkg::OP_DONE) ? '0 : y;
    hy = {tvbe_pkg::TAG_HI, py[9:5]};
    ly = {1'b0, tvbe_pkg::TAG_LO_Y, py[4:0]};
    hx = {tvbe_pkg::TAG_HI, px[9:5]};
    lx = {1'b0, tvbe_pkg::TAG_LO_X, px[4:0]};
    chy = cur.lost || (hy != cur.hi_y);
    chx = cur.lost || (hx != cur.hi_x);
    cly = cur.lost || (ly != cur.lo_y);
    clx = cur.lost || (lx != cur.lo_x);

    for (int k = 0; k < tvbe_pkg::MAX_BYTES; k++) begin
      bytes[k] = '0;
    end
    idx = '0;
    nxt = cur;

    case (operation)
      tvbe_pkg::OP_INIT: begin
        bytes[0] = tvbe_pkg::CH_US;
        bytes[1] = tvbe_pkg::CH_ESC;
        bytes[2] = tvbe_pkg::CH_FF;
        bytes[3] = tvbe_pkg::CH_GS;
        idx = 3'd4;
        nxt.mode = tvbe_pkg::MODE_VECTOR;
        nxt.lost = 1'b1;
      end
      tvbe_pkg::OP_ERASE: begin
        if (cur.mode != tvbe_pkg::MODE_ALPHA) begin
          bytes[idx] = tvbe_pkg::CH_US;
          idx = idx + 1'b1;
        end
        bytes[idx] = tvbe_pkg::CH_ESC;
        idx = idx + 1'b1;
        bytes[idx] = tvbe_pkg::CH_FF;
        idx = idx + 1'b1;
        nxt.mode = tvbe_pkg::MODE_ALPHA;
        nxt.lost = 1'b1;
      end
      tvbe_pkg::OP_MOVE, tvbe_pkg::OP_DONE: begin
        bytes[idx] = tvbe_pkg::CH_GS;
        idx = idx + 1'b1;
      end
      default: begin
      end
    endcase

    if (is_point) begin
      if (chy) begin
        bytes[idx] = hy;
        idx = idx + 1'b1;
      end
      if (cly || chx) begin
        bytes[idx] = ly;
        idx = idx + 1'b1;
      end
      if (chx) begin
        bytes[idx] = hx;
        idx = idx + 1'b1;
      end
      if (chy || chx || cly || clx) begin
        bytes[idx] = lx;
        idx = idx + 1'b1;
      end
      nxt.hi_y = hy;
      nxt.lo_y = ly;
      nxt.hi_x = hx;
      nxt.lo_x = lx;
      nxt.lost = 1'b0;
    end

    if (operation == tvbe_pkg::OP_DONE) begin
      if (cur.mode != tvbe_pkg::MODE_ALPHA) begin
        bytes[idx] = tvbe_pkg::CH_US;
        idx = idx + 1'b1;
      end
      bytes[idx] = tvbe_pkg::CH_NL;
      idx = idx + 1'b1;
      nxt.mode = tvbe_pkg::MODE_ALPHA;
      nxt.lost = 1'b1;
    end

    count = idx;
  end

endmodule

// ===== rtl/tek_vector_byte_encoder.sv =====
// Top level: plot commands in, Tektronix 4010 terminal bytes out.
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | in_valid, in_stall, operation, x_raw,  | command in
//          | y_raw                                  |
//  out     | out_valid, out_stall, out_byte,        | byte out
//          | last_byte                              |
//
// A command passes an input register and three scaler stages, then is
// encoded into a byte buffer, whose first byte drives out_byte.
// The single byte port drains the buffer; the buffer takes the next command's
// bytes only once it is empty or its last byte is leaving.
// Reset (rst, synchronous) empties the pipeline and buffer and clears state.
// out_stall backs up through the stages to in_stall in the same cycle.
module tek_vector_byte_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [15:0] x_raw,
  input  logic [15:0] y_raw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  localparam int NB = tvbe_pkg::MAX_BYTES;

  logic v1;
  logic v2;
  logic v3;
  logic v4;
  logic r1;
  logic r2;
  logic r3;
  logic r4;
  logic [2:0]  op1;
  logic [2:0]  op2;
  logic [2:0]  op3;
  logic [2:0]  op4;
  logic [15:0] x1;
  logic [15:0] y1;
  tvbe_pkg::stage_en_t en;
  logic [tvbe_pkg::COORD_W-1:0] xs;
  logic [tvbe_pkg::COORD_W-1:0] ys;

  tvbe_pkg::term_state_t term;
  tvbe_pkg::term_state_t term_next;
  logic [7:0] enc_bytes [NB];
  logic [tvbe_pkg::CNT_W-1:0] enc_count;

  logic [7:0] obuf [NB];
  logic [tvbe_pkg::CNT_W-1:0] ocnt;
  logic buf_free;
  logic pop;
  logic load;

  assign out_valid = (ocnt != '0);
  assign out_byte  = obuf[0];
  assign last_byte = (ocnt == tvbe_pkg::CNT_W'(1));
  assign pop       = out_valid && !out_stall;
  assign buf_free  = (ocnt == '0) || ((ocnt == tvbe_pkg::CNT_W'(1)) && !out_stall);

  assign r4 = !v4 || buf_free;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_stall = !r1;
  assign load = v4 && buf_free;

  assign en.s2 = r2;
  assign en.s3 = r3;
  assign en.s4 = r4;

  tvbe_scale u_scale_x (
    .clk    (clk),
    .en     (en),
    .raw    (x1),
    .limit  (tvbe_pkg::COORD_W'(tvbe_pkg::MAX_X)),
    .scaled (xs)
  );

  tvbe_scale u_scale_y (
    .clk    (clk),
    .en     (en),
    .raw    (y1),
    .limit  (tvbe_pkg::COORD_W'(tvbe_pkg::MAX_Y)),
    .scaled (ys)
  );

  tvbe_encode u_encode (
    .operation (op4),
    .x         (xs),
    .y         (ys),
    .cur       (term),
    .bytes     (enc_bytes),
    .count     (enc_count),
    .nxt       (term_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      op1 <= operation;
      x1  <= x_raw;
      y1  <= y_raw;
    end
    if (r2) op2 <= op1;
    if (r3) op3 <= op2;
    if (r4) op4 <= op3;
  end

  // Terminal state advances as each command is encoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      term.mode <= tvbe_pkg::MODE_UNKNOWN;
      term.lost <= 1'b0;
      term.hi_y <= '0;
      term.lo_y <= '0;
      term.hi_x <= '0;
      term.lo_x <= '0;
    end else if (load) begin
      term <= term_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else if (load) begin
      ocnt <= enc_count;
    end else if (pop) begin
      ocnt <= ocnt - 1'b1;
    end
  end

  // Load a fresh byte list, or shift the buffer down one byte on each pop.
  always_ff @(posedge clk) begin
    if (load) begin
      obuf <= enc_bytes;
    end else if (pop) begin
      for (int k = 0; k < NB - 1; k++) begin
        obuf[k] <= obuf[k+1];
      end
    end
  end

endmodule

// ===== rtl/tvbe_checker.sv =====
// Port-level checks for the vector byte encoder, bound to the top level.
module tvbe_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  operation,
  input logic [15:0] x_raw,
  input logic [15:0] y_raw,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        last_byte
);

  // a stalled command holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(operation) && $stable(x_raw) &&
      $stable(y_raw))
    else $error("stalled input item changed");

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("stalled output byte changed");

  // a byte that is not last is followed at once by the next one
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_byte |=> out_valid)
    else $error("gap inside a command's byte run");

  // escape is always followed by form feed
  a_esc_ff: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (out_byte == tvbe_pkg::CH_ESC)
      |=> out_valid && (out_byte == tvbe_pkg::CH_FF))
    else $error("escape not followed by form feed");

  // newline ends a command
  a_nl_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_byte == tvbe_pkg::CH_NL) |-> last_byte)
    else $error("newline not marked as last byte");

endmodule

bind tek_vector_byte_encoder tvbe_port_checks u_tvbe_port_checks (.*);
